/* rtl/core/epoch_seconds_to_calendar_defines.svh */
// Assertion macros shared by the calendar converter checker.
// No dependencies; include by bare file name.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/esc_pkg.sv */
// Shared constants, types and the month table for the calendar converter.
// No dependencies.
package esc_pkg;

	localparam int SecsPerHour  = 3600;
	// 86400 = 128 * 675: shift by 7, then divide by 675 with a reciprocal
	localparam int DayShift     = 7;
	localparam int DayOdd       = 675;
	localparam logic [25:0] DayRecip = 26'd50903317;   // ceil(2^35 / 675)
	localparam int DayRecipSh   = 35;

	localparam logic [17:0] HourRecip = 18'd149131;    // ceil(2^29 / 3600)
	localparam logic [17:0] MinRecip  = 18'd139811;    // ceil(2^23 / 60)
	localparam logic [17:0] CycRecip  = 18'd183735;    // ceil(2^28 / 1461)

	localparam int BaseYear     = 1969;    // 4-year cycles counted from 1969
	localparam int DaysPerYear  = 365;
	localparam int DaysPerCycle = 1461;
	localparam int SecsPerMin   = 60;
	// day index of 2100-03-01; 2100 is not a leap year
	localparam logic [15:0] Mar1Of2100 = 16'd47541;

	localparam logic [4:0] ZoneReset = 5'sd9;

	typedef struct packed {
		logic        valid;
		logic        clamped;
		logic [15:0] days;
		logic [16:0] in_day;
	} day_split_t;

	// first day of month idx (0 = January) within the year
	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (idx >= 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

/* rtl/core/esc_day_split.sv */
// Stages 1 to 3: zone offset, clamp, split into whole days and seconds of day.
// Depends on esc_pkg.
module esc_day_split (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [31:0]         epoch_seconds,
	input  logic signed [4:0]   zone_offset_hours,
	output esc_pkg::day_split_t split
);

	logic signed [17:0] off_sec;
	logic signed [33:0] local_sum;

	logic        v_s1, v_s2, v_s3;
	logic        clamped_s1, clamped_s2, clamped_s3;
	logic [32:0] t_s1;
	logic [51:0] prod_s2;
	logic [25:0] q1_s2;
	logic [6:0]  lo7_s2;
	logic [15:0] days_s3;
	logic [16:0] in_day_s3;

	logic [15:0] days_c;
	logic [25:0] rem_c;

	assign off_sec   = 18'(zone_offset_hours) * $signed(18'(esc_pkg::SecsPerHour));
	assign local_sum = $signed({2'b00, epoch_seconds}) + 34'(off_sec);

	assign days_c = prod_s2[esc_pkg::DayRecipSh +: 16];
	assign rem_c  = q1_s2 - 26'(days_c) * 26'(esc_pkg::DayOdd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// negative local time clamps to the epoch
			clamped_s1 <= local_sum[33];
			t_s1       <= local_sum[33] ? 33'd0 : local_sum[32:0];

			prod_s2    <= 52'(t_s1[32:esc_pkg::DayShift]) * 52'(esc_pkg::DayRecip);
			q1_s2      <= t_s1[32:esc_pkg::DayShift];
			lo7_s2     <= t_s1[esc_pkg::DayShift-1:0];
			clamped_s2 <= clamped_s1;

			days_s3    <= days_c;
			in_day_s3  <= {rem_c[9:0], lo7_s2};
			clamped_s3 <= clamped_s2;
		end
	end

	assign split.valid   = v_s3;
	assign split.clamped = clamped_s3;
	assign split.days    = days_s3;
	assign split.in_day  = in_day_s3;

endmodule

/* rtl/core/esc_clock.sv */
// Stages 4 to 6: hour, minute and second from the seconds within the day.
// Depends on esc_pkg.
module esc_clock (
	input  logic        clk,
	input  logic        adv,
	input  logic [16:0] in_day,
	output logic [4:0]  hour_value,
	output logic [5:0]  minute_value,
	output logic [5:0]  second_value
);

	logic [34:0] ph_s4, pm_s4;
	logic [16:0] in_day_s4;
	logic [4:0]  hour_s5, hour_s6;
	logic [5:0]  minute_s5, minute_s6;
	logic [5:0]  second_s5, second_s6;

	logic [4:0]  hours_c;
	logic [10:0] mins_c;
	logic [10:0] minute_c;
	logic [16:0] second_c;

	assign hours_c  = ph_s4[33:29];
	assign mins_c   = pm_s4[33:23];
	assign minute_c = mins_c - 11'(hours_c) * 11'(esc_pkg::SecsPerMin);
	assign second_c = in_day_s4 - 17'(mins_c) * 17'(esc_pkg::SecsPerMin);

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_s4     <= 35'(in_day) * 35'(esc_pkg::HourRecip);
			pm_s4     <= 35'(in_day) * 35'(esc_pkg::MinRecip);
			in_day_s4 <= in_day;

			hour_s5   <= hours_c;
			minute_s5 <= minute_c[5:0];
			second_s5 <= second_c[5:0];

			hour_s6   <= hour_s5;
			minute_s6 <= minute_s5;
			second_s6 <= second_s5;
		end
	end

	assign hour_value   = hour_s6;
	assign minute_value = minute_s6;
	assign second_value = second_s6;

endmodule

/* rtl/core/esc_date.sv */
// Stages 4 to 6: year, month and day of month from the day count.
// Depends on esc_pkg (reciprocals, month table).
module esc_date (
	input  logic        clk,
	input  logic        adv,
	input  logic [15:0] days,
	output logic [11:0] year_value,
	output logic [3:0]  month_value,
	output logic [4:0]  day_value
);

	logic [16:0] e_c;
	logic [16:0] e_s4;
	logic [34:0] pe_s4;
	logic [11:0] year_s5, year_s6;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [3:0]  month_s6;
	logic [4:0]  day_s6;

	logic [5:0]  q4_c;
	logic [10:0] r4_c;
	logic [1:0]  yi_c;
	logic [8:0]  doy_c;
	logic [3:0]  midx_c;
	logic [8:0]  mday_c;

	// Count from 1969 in plain 4-year cycles; past 2100-02-28 one day is added
	// so the missing Feb 29 of 2100 is skipped.
	assign e_c = 17'(days) + 17'(esc_pkg::DaysPerYear) + 17'(days >= esc_pkg::Mar1Of2100);

	assign q4_c  = pe_s4[33:28];
	assign r4_c  = 11'(e_s4 - 17'(q4_c) * 17'(esc_pkg::DaysPerCycle));
	assign yi_c  = 2'(r4_c >= 11'd365) + 2'(r4_c >= 11'd730) + 2'(r4_c >= 11'd1095);
	assign doy_c = 9'(r4_c - 11'(yi_c) * 11'(esc_pkg::DaysPerYear));

	always_comb begin
		midx_c = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy_s5 >= esc_pkg::month_start(4'(k), leap_s5)) begin
				midx_c = 4'(k);
			end
		end
		mday_c = doy_s5 - esc_pkg::month_start(midx_c, leap_s5) + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s4     <= e_c;
			pe_s4    <= 35'(e_c) * 35'(esc_pkg::CycRecip);

			year_s5  <= 12'(esc_pkg::BaseYear) + 12'({q4_c, 2'b00}) + 12'(yi_c);
			doy_s5   <= doy_c;
			leap_s5  <= (yi_c == 2'd3);

			year_s6  <= year_s5;
			month_s6 <= midx_c + 4'd1;
			day_s6   <= mday_c[4:0];
		end
	end

	assign year_value  = year_s6;
	assign month_value = month_s6;
	assign day_value   = day_s6;

endmodule

/* rtl/core/epoch_seconds_to_calendar.sv */
// Top level of the epoch seconds to local calendar converter.
// Depends on esc_pkg, esc_day_split, esc_date, esc_clock.

// Converts 32-bit Unix seconds to local year, month, day, hour, minute and
// second after adding the zone offset in whole hours (cfg_wr_data, signed,
// reset +9). A local time before the epoch reads as 1970-01-01 00:00:00 with
// m_tuser set. The converter is a six-stage pipeline: one word is taken every
// cycle while the output is not stalled, and its result passes through the
// registers of stages 1 to 6 in order before it shows on the master side.
// The stage count is set by the chain of reciprocal multiplies (by days, then
// by 4-year cycles and by hours/minutes), each followed by a register. When
// m_tready is low with a result waiting, the whole pipeline holds.
module epoch_seconds_to_calendar (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,  // zone_offset_hours, signed
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // [31:0] epoch_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] year_value, [15:12] month_value, [20:16] day_value,
	// [25:21] hour_value, [31:26] minute_value, [37:32] second_value, [39:38] zero
	output logic [39:0] m_tdata,
	output logic        m_tuser       // [0] clamped_flag
);

	logic signed [4:0]   zone_q;
	logic                adv;
	esc_pkg::day_split_t split;

	logic v_s4, v_s5, v_s6;
	logic clamped_s4, clamped_s5, clamped_s6;

	logic [11:0] year_value;
	logic [3:0]  month_value;
	logic [4:0]  day_value;
	logic [4:0]  hour_value;
	logic [5:0]  minute_value;
	logic [5:0]  second_value;

	assign adv      = !v_s6 || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= esc_pkg::ZoneReset;
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	esc_day_split u_split (
		.clk               (clk),
		.arst_n            (arst_n),
		.adv               (adv),
		.in_valid          (s_tvalid),
		.epoch_seconds     (s_tdata),
		.zone_offset_hours (zone_q),
		.split             (split)
	);

	esc_date u_date (
		.clk         (clk),
		.adv         (adv),
		.days        (split.days),
		.year_value  (year_value),
		.month_value (month_value),
		.day_value   (day_value)
	);

	esc_clock u_clock (
		.clk          (clk),
		.adv          (adv),
		.in_day       (split.in_day),
		.hour_value   (hour_value),
		.minute_value (minute_value),
		.second_value (second_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s4 <= split.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clamped_s4 <= split.clamped;
			clamped_s5 <= clamped_s4;
			clamped_s6 <= clamped_s5;
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {2'b00, second_value, minute_value, hour_value,
		day_value, month_value, year_value};
	assign m_tuser  = clamped_s6;

endmodule

/* rtl/core/esc_checker.sv */
// Port-level checks for the calendar converter, bound to the top level.
// Depends on epoch_seconds_to_calendar_defines.svh.
`include "epoch_seconds_to_calendar_defines.svh"

module esc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result word holds
	`ESC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// the input side never waits on an empty output
	`ESC_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with no result pending")

	`ESC_ASSERT_NOW(a_fields_range, m_tvalid, (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) && (m_tdata[20:16] >= 5'd1) && (m_tdata[25:21] <= 5'd23) && (m_tdata[31:26] <= 6'd59) && (m_tdata[37:32] <= 6'd59) && (m_tdata[11:0] >= 12'd1970) && (m_tdata[11:0] <= 12'd2106), "result field out of range")

	// a clamped result is exactly the epoch
	`ESC_ASSERT_NOW(a_clamp_epoch, m_tvalid && m_tuser, m_tdata == {2'b00, 6'd0, 6'd0, 5'd0, 5'd1, 4'd1, 12'd1970}, "clamped result is not the epoch")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

/* verif/epoch_calendar_checker.sv */
// Scoreboard for the epoch seconds to calendar converter: tracks the zone offset register,
// predicts the local date of every accepted word and compares each result word in order.
// Depends on esc_pkg for the register reset value.
module epoch_calendar_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	output int          mismatch_count,
	output int          open_dates,
	output int          dates_checked,
	output int          clamped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        clamped;
	} calendar_t;

	logic signed [4:0] zone_hours;
	calendar_t         expected_dates[$];

	initial begin
		mismatch_count = 0;
		open_dates     = 0;
		dates_checked  = 0;
		clamped_seen   = 0;
	end

	function automatic bit leap_year(input int yr);
		return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
	endfunction

	function automatic int month_length(input int mon, input bit leap);
		case (mon)
			2:           return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	function automatic calendar_t local_calendar_of(input logic [31:0] secs,
			input logic signed [4:0] zone);
		longint    local_secs;
		longint    days;
		int        in_day;
		int        yr;
		int        mon;
		int        span;
		calendar_t cal;
		local_secs = longint'({32'd0, secs}) + longint'(zone) * 3600;
		cal.clamped = 1'b0;
		if (local_secs < 0) begin
			local_secs = 0;
			cal.clamped = 1'b1;
		end
		days = local_secs / 86400;
		in_day = int'(local_secs % 86400);
		// a year is only stripped while a whole year of days is left
		yr = 1970;
		span = leap_year(yr) ? 366 : 365;
		while (days >= span) begin
			days -= span;
			yr++;
			span = leap_year(yr) ? 366 : 365;
		end
		mon = 1;
		span = month_length(mon, leap_year(yr));
		while (mon < 12 && days >= span) begin
			days -= span;
			mon++;
			span = month_length(mon, leap_year(yr));
		end
		cal.year   = 12'(yr);
		cal.month  = 4'(mon);
		cal.day    = 5'(days + 1);
		cal.hour   = 5'(in_day / 3600);
		cal.minute = 6'((in_day % 3600) / 60);
		cal.second = 6'(in_day % 60);
		return cal;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_hours <= esc_pkg::ZoneReset;
		end else if (cfg_wr_en) begin
			zone_hours <= cfg_wr_data;
		end
	end

	always @(posedge clk) begin
		calendar_t want;
		calendar_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_dates = {expected_dates, local_calendar_of(s_tdata, zone_hours)};
			end
			if (m_tvalid && m_tready) begin
				got.year    = m_tdata[11:0];
				got.month   = m_tdata[15:12];
				got.day     = m_tdata[20:16];
				got.hour    = m_tdata[25:21];
				got.minute  = m_tdata[31:26];
				got.second  = m_tdata[37:32];
				got.clamped = m_tuser;
				if (expected_dates.size() == 0) begin
					mismatch_count++;
					$error("result word with no date pending");
				end else begin
					want = expected_dates.pop_front();
					check_field("year_value", int'(want.year), int'(got.year));
					check_field("month_value", int'(want.month), int'(got.month));
					check_field("day_value", int'(want.day), int'(got.day));
					check_field("hour_value", int'(want.hour), int'(got.hour));
					check_field("minute_value", int'(want.minute), int'(got.minute));
					check_field("second_value", int'(want.second), int'(got.second));
					check_field("clamped_flag", int'(want.clamped), int'(got.clamped));
					dates_checked++;
					if (want.clamped) begin
						clamped_seen++;
					end
				end
			end
			open_dates = expected_dates.size();
		end
	end

endmodule

/* verif/epoch_seconds_to_calendar_test.sv */
// Top of the calendar converter testbench: clock, reset, zone offset writes, word
// stimulus with idle and stall patterns, and the verdict. Depends on the block and
// epoch_calendar_checker.
module epoch_seconds_to_calendar_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 300000;

	typedef enum logic [2:0] {FlowFree, SenderIdle, ReceiverStall, BothIdle, LongHold} flow_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = 5'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	int mismatch_count;
	int open_dates;
	int dates_checked;
	int clamped_seen;

	flow_mode_t flow_mode = FlowFree;
	int         hold_left = 0;
	int         holds_done = 0;
	int         offsets_used = 1;

	// boundaries in local time under the reset offset of +9 h
	logic [31:0] reset_zone_words[$] = '{32'd0, 32'hFFFFFFFF, 32'd53999, 32'd54000,
		32'd31503600, 32'd68137200, 32'd951750000, 32'd978274799, 32'd978274800,
		32'd4107509999, 32'd4107510000, 32'h7FFFFFFF, 32'h80000000,
		32'h55555555, 32'hAAAAAAAA};
	// -12 h: clamped below 43200, exactly midnight at 43200
	logic [31:0] west_zone_words[$] = '{32'd0, 32'd43199, 32'd43200, 32'hFFFFFFFF};
	logic [31:0] east_zone_words[$] = '{32'hFFFFFFFF, 32'd0, 32'd1};

	epoch_seconds_to_calendar DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	epoch_calendar_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.open_dates     (open_dates),
		.dates_checked  (dates_checked),
		.clamped_seen   (clamped_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int sender_idle_pct(input flow_mode_t mode);
		case (mode)
			SenderIdle: return 77;
			BothIdle:   return 17;
			default:    return 0;
		endcase
	endfunction

	function automatic int receiver_stall_pct(input flow_mode_t mode);
		case (mode)
			ReceiverStall: return 77;
			BothIdle:      return 17;
			default:       return 0;
		endcase
	endfunction

	// receiver; in the hold phase it starts long hold-offs so the pipeline backs up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (flow_mode == LongHold && (holds_done == 0 || $urandom_range(99) < 2)) begin
			m_tready <= 1'b0;
			hold_left <= $urandom_range(120, 60);
			holds_done <= holds_done + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct(flow_mode));
		end
	end

	// seconds that land near year, leap-day and day boundaries in local time, near either end of the range, or at random
	function automatic logic [31:0] pick_seconds(input int hours);
		longint target;
		longint spread;
		int     yr;
		int     kind;
		kind = $urandom_range(99);
		if (kind < 35) begin
			return $urandom;
		end else if (kind < 85) begin
			if (kind < 70) begin
				yr = $urandom_range(2106, 1970);
				target = 0;
				for (int y = 1970; y < yr; y++) begin
					target += ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 366 : 365;
				end
				if (kind >= 55) begin
					target += 59;   // around the end of February
				end
				target *= 86400;
				spread = 2 * 86400;
			end else begin
				target = longint'($urandom_range(49709)) * 86400;
				spread = 3;
			end
			target += longint'($urandom_range(int'(2 * spread))) - spread - longint'(hours) * 3600;
			if (target < 0 || target > 64'hFFFFFFFF) begin
				return $urandom;
			end
			return target[31:0];
		end else if (kind < 95) begin
			return $urandom_range(100000);
		end
		return 32'hFFFFFFFF - $urandom_range(100000);
	endfunction

	// valid stays high across back-to-back words
	task automatic send_word(input logic [31:0] secs);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < sender_idle_pct(flow_mode)) begin
			gap++;
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= secs;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic end_burst();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// register writes only with the pipeline drained
	task automatic begin_phase(input flow_mode_t mode, input int hours);
		while (open_dates != 0) begin
			@(negedge clk);
		end
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hours[4:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		flow_mode = mode;
		offsets_used++;
	endtask

	task automatic random_burst(input flow_mode_t mode, input int hours, input int count);
		begin_phase(mode, hours);
		repeat (count) begin
			send_word(pick_seconds(hours));
		end
		end_burst();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (reset_zone_words[i]) begin
			send_word(reset_zone_words[i]);
		end
		end_burst();
		begin_phase(FlowFree, -12);
		foreach (west_zone_words[i]) begin
			send_word(west_zone_words[i]);
		end
		end_burst();
		begin_phase(FlowFree, 14);
		foreach (east_zone_words[i]) begin
			send_word(east_zone_words[i]);
		end
		end_burst();

		random_burst(FlowFree, 0, 90);
		random_burst(SenderIdle, -16, 90);
		random_burst(ReceiverStall, 15, 90);
		random_burst(BothIdle, int'($urandom_range(31)) - 16, 90);
		random_burst(LongHold, 9, 90);

		while (open_dates != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);

		$display("Checked %0d dates under %0d zone offsets, %0d of them clamped to the epoch.",
			dates_checked, offsets_used, clamped_seen);
		$display("Flow patterns: free, sender idle, receiver stall, both, and %0d long hold-offs.",
			holds_done);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("Timed out after %0d cycles with %0d dates outstanding", CycleLimit, open_dates);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_day_split.sv
rtl/core/esc_clock.sv
rtl/core/esc_date.sv
rtl/core/epoch_seconds_to_calendar.sv
rtl/core/esc_checker.sv
verif/epoch_calendar_checker.sv
verif/epoch_seconds_to_calendar_test.sv
